// ----- sv/delay_line_pitch_shifter_macros.svh -----
// assertion macros for the delay line pitch shifter checker
// no dependencies; expects a clock named clk and a reset named rst in scope
`ifndef DELAY_LINE_PITCH_SHIFTER_MACROS_SVH
`define DELAY_LINE_PITCH_SHIFTER_MACROS_SVH

// next-cycle implication, quiet while reset is high
`define DLPS_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

// next-cycle implication that also holds through reset
`define DLPS_ASSERT_NEXT_ALWAYS(label, cond, expr, msg) \
  label: assert property (@(posedge clk) (cond) |=> (expr)) else $error(msg);

`endif

// ----- sv/dlps_pkg.sv -----
// shared types and constants for the delay line pitch shifter
// no dependencies
`default_nettype none

package dlps_pkg;

  // payload and register widths
  localparam int SAMPLE_W   = 16;
  localparam int STEP_W     = 9;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // shared multiplier operand and accumulator widths
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int ACC_W   = SAMPLE_W + MUL_B_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_READ_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_GAIN  = 2'd1;

  // register reset values
  localparam logic [STEP_W-1:0] READ_STEP_RESET = 9'd256;
  localparam logic [GAIN_W-1:0] MIX_GAIN_RESET  = 16'd32767;

  // control of the shared multiply-accumulate unit
  typedef struct packed {
    logic en;     // load a new result this cycle
    logic accum;  // add product to the held sum instead of replacing it
  } mac_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/dlps_mac.sv -----
// shared signed multiply-accumulate unit with a registered sum
// depends on dlps_pkg
`default_nettype none

module dlps_mac (
  input  wire logic                                   clk,
  input  wire dlps_pkg::mac_ctrl_t                    ctrl,
  input  wire logic signed [dlps_pkg::SAMPLE_W-1:0]   a,
  input  wire logic signed [dlps_pkg::MUL_B_W-1:0]    b,
  output logic signed [dlps_pkg::ACC_W-1:0]           acc
);
  import dlps_pkg::*;

  logic signed [ACC_W-1:0] prod;

  // one product per cycle, optionally added to the held sum
  assign prod = ACC_W'(a) * ACC_W'(b);

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc <= ctrl.accum ? acc + prod : prod;
    end
  end

endmodule

`default_nettype wire

// ----- sv/delay_line_pitch_shifter.sv -----
// top level of the delay line pitch shifter: sequencer, delay memory, registers
// depends on dlps_pkg and dlps_mac
`default_nettype none

// channel  | handshake                 | payload
// ---------+---------------------------+---------------------------
// input    | in_valid / in_stall       | in_sample (signed 16)
// output   | out_valid / out_stall     | out_sample (signed 16)
// config   | cfg_we                    | cfg_index, cfg_data
//
// an item runs through read, multiply, gain and done states before the next is
// taken, plus a second multiply when the read slot is inside the crossfade window:
// the single shared multiplier, after a read step, is used twice for a crossfade
// and once for the gain. after reset a clearing pass zeroes every slot of the delay
// memory with in_stall high; config writes are taken during it.
// a stalled result holds the sequencer in its gain step; the next item is still
// taken while a finished result waits in the output register.

module delay_line_pitch_shifter #(
  parameter int BUFFER_DEPTH = 512,
  parameter int FADE_SHIFT   = 4,
  parameter int FRAC_BITS    = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [dlps_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [dlps_pkg::SAMPLE_W-1:0]        out_sample,
  input  wire logic                                   cfg_we,
  input  wire logic [dlps_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [dlps_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import dlps_pkg::*;

  localparam int AW       = $clog2(BUFFER_DEPTH);
  localparam int POS_MOD  = BUFFER_DEPTH << FRAC_BITS;
  localparam int PW       = $clog2(POS_MOD);
  localparam int FADE_LEN = 1 << FADE_SHIFT;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_MUL1  = 7'b0001000,
    S_MUL2  = 7'b0010000,
    S_GAIN  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [STEP_W-1:0] read_step;
  logic [GAIN_W-1:0] mix_gain;

  logic [AW-1:0] write_index;
  logic [PW-1:0] read_position;
  logic [AW-1:0] clr_cnt;

  logic [AW-1:0]                wi_cur;
  logic [AW-1:0]                ri_cur;
  logic [AW-1:0]                d_reg;
  logic                         fade;
  logic signed [SAMPLE_W-1:0]   x_reg;
  logic signed [SAMPLE_W-1:0]   rd_data;

  logic signed [SAMPLE_W-1:0]   mem [BUFFER_DEPTH];
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic signed [SAMPLE_W-1:0]   mem_wdata;

  logic                         accept;
  logic                         out_free;
  logic [PW:0]                  pos_sum;
  logic [PW-1:0]                pos_next;
  logic [AW:0]                  dif;
  logic [AW:0]                  d_mod;

  mac_ctrl_t                    mac_ctrl;
  logic signed [SAMPLE_W-1:0]   mac_a;
  logic signed [MUL_B_W-1:0]    mac_b;
  logic signed [ACC_W-1:0]      acc;

  assign accept   = (state == S_IDLE) && in_valid;
  assign in_stall = (state != S_IDLE);
  assign out_free = !(out_valid && out_stall);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      read_step <= READ_STEP_RESET;
      mix_gain  <= MIX_GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_READ_STEP: read_step <= cfg_data[STEP_W-1:0];
        REG_MIX_GAIN:  mix_gain  <= cfg_data[GAIN_W-1:0];
        default:       ;
      endcase
    end
  end

  // read position advance, wrapped at the position modulus
  always_comb begin
    pos_sum = {1'b0, read_position} + (PW+1)'(read_step);
    if (pos_sum >= (PW+1)'(POS_MOD)) begin
      pos_next = PW'(pos_sum - (PW+1)'(POS_MOD));
    end else begin
      pos_next = pos_sum[PW-1:0];
    end
  end

  // distance from write slot to read slot, modulo the depth
  always_comb begin
    dif = {1'b0, ri_cur} - {1'b0, wi_cur};
    if (dif[AW]) begin
      d_mod = dif + (AW+1)'(BUFFER_DEPTH);
    end else begin
      d_mod = dif;
    end
  end

  // delay memory write port: clearing pass or incoming sample
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = write_index;
    mem_wdata = in_sample;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else if (accept) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state == S_READ) begin
      rd_data <= mem[ri_cur];
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_cnt == AW'(BUFFER_DEPTH - 1)) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_READ;
      S_READ:  state_next = S_MUL1;
      S_MUL1:  state_next = fade ? S_MUL2 : S_GAIN;
      S_MUL2:  state_next = S_GAIN;
      S_GAIN:  if (out_free) state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == S_CLEAR) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // write index and read position
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index   <= '0;
      read_position <= '0;
    end else if (accept) begin
      write_index   <= (write_index == AW'(BUFFER_DEPTH - 1)) ? '0 : write_index + AW'(1);
      read_position <= pos_next;
    end
  end

  // per-transaction working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      x_reg  <= in_sample;
      wi_cur <= write_index;
      ri_cur <= read_position[PW-1:FRAC_BITS];
    end
    if (state == S_READ) begin
      d_reg <= d_mod[AW-1:0];
      fade  <= (32'(d_mod) < FADE_LEN);
    end
  end

  // shared multiplier operand selection
  always_comb begin
    mac_ctrl = '0;
    mac_a    = rd_data;
    mac_b    = $signed({1'b0, 16'(d_reg)});
    case (state)
      S_MUL1: begin
        mac_ctrl.en = fade;
      end
      S_MUL2: begin
        mac_ctrl.en    = 1'b1;
        mac_ctrl.accum = 1'b1;
        mac_a          = x_reg;
        mac_b          = $signed({1'b0, 16'(FADE_LEN) - 16'(d_reg)});
      end
      S_GAIN: begin
        mac_ctrl.en = out_free;
        mac_a       = fade ? acc[FADE_SHIFT+SAMPLE_W-1:FADE_SHIFT] : rd_data;
        mac_b       = $signed({1'b0, mix_gain});
      end
      default: ;
    endcase
  end

  dlps_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .a    (mac_a),
    .b    (mac_b),
    .acc  (acc)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      out_sample <= acc[GAIN_W+SAMPLE_W-1:GAIN_W];
    end
  end

endmodule

`default_nettype wire

// ----- sv/delay_line_pitch_shifter_chk.sv -----
// port-level checker for the delay line pitch shifter, bound to the top level
// depends on delay_line_pitch_shifter_macros.svh
`default_nettype none
`include "delay_line_pitch_shifter_macros.svh"

module delay_line_pitch_shifter_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_sample
);

  // a stalled result stays offered and unchanged
  `DLPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `DLPS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_sample), "result changed while stalled")

  // the block is busy in the cycle after it takes a transaction
  `DLPS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted twice in a row")

  // reset starts the clearing pass, which refuses input
  `DLPS_ASSERT_NEXT_ALWAYS(a_clear_after_reset, rst, in_stall && !out_valid, "input open after reset")

endmodule

bind delay_line_pitch_shifter delay_line_pitch_shifter_chk u_chk (.*);

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// testbench for delay_line_pitch_shifter: random bursts of samples against a cycle-free predictor
// depends on dlps_pkg and the delay_line_pitch_shifter rtl

import dlps_pkg::*;

// geometry the block is built with here
localparam int DELAY_DEPTH = 512;
localparam int FADE_SHIFT  = 4;
localparam int FRAC_BITS   = 8;
localparam int FADE_LEN    = 1 << FADE_SHIFT;
localparam int INDEX_W     = $clog2(DELAY_DEPTH);
localparam int POS_W       = INDEX_W + FRAC_BITS;

// register indexes with nothing behind them
localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

// shifter state mirror and queue of predicted output samples
class pitch_shift_scoreboard;
  logic signed [SAMPLE_W-1:0] delay_store [DELAY_DEPTH];
  logic [INDEX_W-1:0]         write_index;
  logic [POS_W-1:0]           read_position;
  logic [STEP_W-1:0]          read_step;
  logic [GAIN_W-1:0]          mix_gain;
  logic signed [SAMPLE_W-1:0] expected_samples[$];
  int samples_noted;
  int results_checked;
  int fades_seen;
  int mismatches;

  function new();
    foreach (delay_store[i]) delay_store[i] = '0;
    write_index     = '0;
    read_position   = '0;
    read_step       = READ_STEP_RESET;
    mix_gain        = MIX_GAIN_RESET;
    samples_noted   = 0;
    results_checked = 0;
    fades_seen      = 0;
    mismatches      = 0;
  endfunction

  // register write, masked to the register width
  function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_READ_STEP: read_step = data[STEP_W-1:0];
      REG_MIX_GAIN:  mix_gain = data[GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  // accepted input: write, read behind or ahead, crossfade, scale
  function void note_sample(logic signed [SAMPLE_W-1:0] sample);
    logic [INDEX_W-1:0] wr_slot;
    logic [INDEX_W-1:0] rd_slot;
    logic [INDEX_W-1:0] gap;
    int     weight;
    longint held;
    longint mixed;
    longint scaled;
    wr_slot = write_index;
    delay_store[wr_slot] = sample;
    rd_slot = read_position[POS_W-1:FRAC_BITS];
    read_position = read_position + read_step;
    held = delay_store[rd_slot];
    gap = rd_slot - wr_slot;
    if (gap < FADE_LEN) begin
      weight = FADE_LEN - int'(gap);
      mixed = held * longint'(gap) + longint'(sample) * longint'(weight);
      held = mixed >>> FADE_SHIFT;
      fades_seen++;
    end
    write_index = wr_slot + 1'b1;
    scaled = (held * longint'(mix_gain)) >>> GAIN_W;
    expected_samples.push_back(scaled[SAMPLE_W-1:0]);
    samples_noted++;
  endfunction

  // accepted output against the oldest prediction
  function void check_result(logic signed [SAMPLE_W-1:0] actual);
    logic signed [SAMPLE_W-1:0] want;
    if (expected_samples.size() == 0) begin
      mismatches++;
      $display("%0t: out_sample %0d arrived with nothing expected", $time, actual);
      return;
    end
    want = expected_samples.pop_front();
    results_checked++;
    if (actual !== want) begin
      mismatches++;
      $display("%0t: out_sample mismatch, expected %0d actual %0d", $time, want, actual);
    end
  endfunction

  function int pending();
    return expected_samples.size();
  endfunction
endclass

module tb_top;

  localparam int HALF_PERIOD        = 5;
  localparam int DRAIN_CYCLES       = 16;
  localparam int CYCLE_LIMIT        = 500000;
  localparam int RANDOM_SETTINGS    = 8;
  localparam int SAMPLES_PER_SETTING = 190;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BLOCK} stall_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pitch_shift_scoreboard model;
  stall_mode_e stall_mode = STALL_NONE;
  int stall_span = 0;
  int settings_applied = 0;
  int cycles_run;

  delay_line_pitch_shifter #(
    .BUFFER_DEPTH(DELAY_DEPTH),
    .FADE_SHIFT(FADE_SHIFT),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sample(in_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sample(out_sample),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock
  always begin
    clk = 1'b0;
    #(HALF_PERIOD);
    clk = 1'b1;
    #(HALF_PERIOD);
  end

  // output monitor and receiver stall pattern
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      model.check_result(out_sample);
    end
    if (stall_span == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_span <= $urandom_range(16, 160);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 4) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_span % 24) < 18;
    endcase
  end

  // watchdog
  initial begin
    for (cycles_run = 0; cycles_run < CYCLE_LIMIT; cycles_run++) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", cycles_run, model.pending());
    $display("CHECK FAILED");
    $finish;
  end

  // mostly random samples, with full-scale and near-zero values weighted up
  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return ($urandom_range(0, 1) == 0) ? 16'sh0000 : 16'shffff;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // send samples in bursts with random gaps; fixed values go first
  task automatic stream_samples(input int count, input logic signed [SAMPLE_W-1:0] fixed[$]);
    int burst_left;
    int gap;
    logic signed [SAMPLE_W-1:0] value;
    burst_left = $urandom_range(1, 24);
    for (int i = 0; i < count; i++) begin
      value = (i < fixed.size()) ? fixed[i] : random_sample();
      in_valid  <= 1'b1;
      in_sample <= value;
      do @(posedge clk); while (in_stall);
      model.note_sample(value);
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;
  endtask

  // wait until every predicted output has been seen and the block is quiet
  task automatic settle();
    while (model.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register write; cfg_we is left high for back-to-back writes
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    model.write_register(idx, data);
  endtask

  // new step and gain, junk in the unused step bits, plus a write to an empty index
  task automatic apply_setting(input logic [STEP_W-1:0] step, input logic [GAIN_W-1:0] gain);
    settle();
    write_register(REG_READ_STEP, {7'($urandom), step});
    write_register(REG_MIX_GAIN, gain);
    write_register(($urandom_range(0, 1) == 0) ? REG_UNUSED_2 : REG_UNUSED_3,
                   CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // main sequence
  initial begin
    logic signed [SAMPLE_W-1:0] opening[$];
    logic signed [SAMPLE_W-1:0] fade_run[$];
    logic signed [SAMPLE_W-1:0] muted[$];
    logic signed [SAMPLE_W-1:0] no_fixed[$];
    logic [STEP_W-1:0] steps[RANDOM_SETTINGS];
    logic [GAIN_W-1:0] gains[RANDOM_SETTINGS];
    model = new();
    in_valid  <= 1'b0;
    in_sample <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_READ_STEP;
    cfg_data  <= '0;

    // reset defaults: read slot equals write slot, so the fade returns the input
    opening  = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff,
                 16'sh0001, 16'sh4000, 16'shc000, 16'sh2a5b};
    // near double speed: read pulls ahead of write, staying inside the fade window
    fade_run = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'shffff, 16'sh0001,
                 16'sh7fff, 16'sh8000, 16'sh0000, 16'sh7fff, 16'sh8000, 16'sh5a5a};
    // zero step and zero gain
    muted    = '{16'sh7fff, 16'sh8000, 16'shffff, 16'sh1234};

    steps = '{9'd0, 9'd511, 9'd128, 9'd384, 9'd257, 9'd255, 9'd0, 9'd0};
    gains = '{16'hffff, 16'h0001, 16'hc000, 16'hffff, 16'h4e20, 16'h7fff, 16'h0, 16'h0};
    steps[RANDOM_SETTINGS-2] = STEP_W'($urandom);
    steps[RANDOM_SETTINGS-1] = STEP_W'($urandom);
    gains[RANDOM_SETTINGS-2] = GAIN_W'($urandom);
    gains[RANDOM_SETTINGS-1] = GAIN_W'($urandom);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part
    stream_samples(opening.size(), opening);
    apply_setting(9'd511, 16'hffff);
    stream_samples(fade_run.size(), fade_run);
    apply_setting(9'd0, 16'h0000);
    stream_samples(muted.size(), muted);

    // random part
    for (int p = 0; p < RANDOM_SETTINGS; p++) begin
      apply_setting(steps[p], gains[p]);
      stream_samples(SAMPLES_PER_SETTING, no_fixed);
    end
    settle();

    $display("sent %0d samples under %0d register settings in %0d cycles",
             model.samples_noted, settings_applied + 1, cycles_run);
    $display("compared %0d outputs, %0d of them read inside the crossfade window",
             model.results_checked, model.fades_seen);
    if (model.mismatches == 0 && model.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
